// File: hdl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants of the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

  // Defaults of the top-level parameters
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths of the stream words
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ELEM_W = 32;
  localparam int SLOT_W = 6;
  localparam int ST_W   = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 3;
  localparam int S_PAD_W   = S_TDATA_W - POS_W - VAL_W;
  localparam int M_PAD_W   = M_TDATA_W - ELEM_W - SLOT_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_REPORT
  } cmd_e;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_e              op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    status_e           status;
    logic              empty;
  } cmd_t;

  // Queue fill flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SHIFT,
    B_STREAM,
    B_REPORT
  } back_state_e;

endpackage

// File: hdl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array of signed words with insert and delete at a position; every
// successful operation streams the updated array out word by word, or one empty-array word when none are left.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tuser: kind; tdata: position, value
// m_*      out  m_tvalid/m_tready    tuser: status, is_empty; tdata: element,
//                                    slot; tlast: last word of the operation
//
// An accepted word enters a two-entry command queue. The back end then
// takes the command, shifts the array one moved entry at a time (an insert
// then writes the new value), and streams the array out. A delete that
// empties the array gives one empty-array word instead, and a fault gives
// one report word. The single read port of the array memory is shared by
// the shift and the readout.
// Reset clears the count and all control state; the array contents are not
// cleared, since only entries below the count are ever read.
// Stalls on the output hold the back end; the queue keeps taking input words
// until it is full.
//
module positional_insert_delete_array #(
  parameter int DEPTH     = pida_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pida_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input words
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic                           s_tuser_i,  // [0] kind
  input  logic [pida_pkg::S_TDATA_W-1:0] s_tdata_i,  // [6:0] position, [38:7] value, [39] 0
  // Result words
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [pida_pkg::M_TDATA_W-1:0] m_tdata_o,  // [31:0] element, [37:32] slot, [39:38] 0
  output logic [pida_pkg::M_TUSER_W-1:0] m_tuser_o,  // [1:0] status, [2] is_empty
  output logic                           m_tlast_o
);
  import pida_pkg::*;

  cmd_t    cmd_in, cmd_out;
  logic    cmd_push, cmd_pop;
  q_stat_t q_stat;

  // Front: classify each word against the count it will find
  pida_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tuser_i  (s_tuser_i),
    .s_tdata_i  (s_tdata_i),
    .cmd_o      (cmd_in),
    .cmd_push_o (cmd_push),
    .q_stat_i   (q_stat)
  );

  // Queue: decouple classification from execution
  pida_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (cmd_pop),
    .cmd_o  (cmd_out),
    .stat_o (q_stat)
  );

  // Back: shift the array memory and stream the result words
  pida_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .q_stat_i   (q_stat),
    .pop_o      (cmd_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // An empty-array word is always the only word of its operation
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[2]) |-> m_tlast_o)
    else $error("empty result word without last");

  // A fault word is single, with zero element and slot
  a_fault_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o[1:0] != ST_DONE))
      |-> (m_tlast_o && (m_tdata_o[ELEM_W+SLOT_W-1:0] == '0)))
    else $error("fault result word malformed");

  // The front never pushes into a full queue
  a_queue_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // The back only takes a command that is there
  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

endmodule

// File: hdl/pida_front.sv
// ----------------------------------------------------------------------------
// pida_front
// Accept input words, check them against the running count and queue commands.
// ----------------------------------------------------------------------------
module pida_front #(
  parameter int DEPTH = pida_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic                          s_tuser_i,   // kind
  input  logic [pida_pkg::S_TDATA_W-1:0] s_tdata_i,  // position, value, zero pad
  output pida_pkg::cmd_t                cmd_o,
  output logic                          cmd_push_o,
  input  pida_pkg::q_stat_t             q_stat_i
);
  import pida_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [POS_W-1:0] pos;
  logic [MW-1:0]    posx, cntx;

  assign pos        = s_tdata_i[POS_W-1:0];
  assign posx       = MW'(pos);
  assign cntx       = MW'(cnt_q);
  assign s_tready_o = !q_stat_i.full;
  assign cmd_push_o = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o.op     = CMD_REPORT;
    cmd_o.pos    = pos;
    cmd_o.value  = s_tdata_i[POS_W +: VAL_W];
    cmd_o.status = ST_DONE;
    cmd_o.empty  = 1'b0;
    cnt_d        = cnt_q;
    if (kind_e'(s_tuser_i) == KIND_INSERT) begin
      if (posx > cntx) begin
        cmd_o.status = ST_RANGE;
        cmd_o.empty  = (cnt_q == '0);
      end else if (cnt_q == CW'(DEPTH)) begin
        cmd_o.status = ST_FULL;
      end else begin
        cmd_o.op = CMD_INSERT;
        cnt_d    = cnt_q + 1'b1;
      end
    end else begin
      if (posx >= cntx) begin
        cmd_o.status = ST_RANGE;
        cmd_o.empty  = (cnt_q == '0);
      end else begin
        cmd_o.op = CMD_DELETE;
        cnt_d    = cnt_q - 1'b1;
      end
    end
  end

  // Track the count as it will stand after every queued command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_push_o) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/pida_queue.sv
// ----------------------------------------------------------------------------
// pida_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pida_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pida_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output pida_pkg::cmd_t    cmd_o,
  output pida_pkg::q_stat_t stat_o
);
  import pida_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (num_q == NW'(QUEUE_DEPTH));
  assign stat_o.empty = (num_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = slots_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        num_q <= num_q + 1'b1;
      end else if (do_pop && !do_push) begin
        num_q <= num_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/pida_back.sv
// ----------------------------------------------------------------------------
// pida_back
// Carry out queued commands on the array memory and stream the result words.
// ----------------------------------------------------------------------------
module pida_back #(
  parameter int DEPTH     = pida_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pida_pkg::WORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pida_pkg::cmd_t                 cmd_i,
  input  pida_pkg::q_stat_t              q_stat_i,
  output logic                           pop_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [pida_pkg::M_TDATA_W-1:0] m_tdata_o,  // element, slot, zero pad
  output logic [pida_pkg::M_TUSER_W-1:0] m_tuser_o,  // status, is_empty
  output logic                           m_tlast_o
);
  import pida_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = (WORD_BITS > ELEM_W) ? WORD_BITS : ELEM_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  back_state_e          state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ins_q, ins_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  logic [AW-1:0]        dst_q, dst_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        wdst_q, wdst_d;
  logic [WORD_BITS-1:0] rdata_q;
  logic [CW-1:0]        k_q, k_d;
  logic                 rv_q, rv_d;
  logic [CW-1:0]        rslot_q, rslot_d;
  status_e              rep_st_q, rep_st_d;
  logic                 rep_empty_q, rep_empty_d;

  logic                 ov_q, ov_d;
  status_e              ost_q, ost_d;
  logic [ELEM_W-1:0]    oel_q, oel_d;
  logic [SLOT_W-1:0]    oslot_q, oslot_d;
  logic                 oempty_q, oempty_d;
  logic                 olast_q, olast_d;

  logic                 we, re, adv;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [MW-1:0]        posx, cntx;
  logic [EW-1:0]        val_ext;
  logic signed [WORD_BITS-1:0] rd_signed;
  logic signed [EW-1:0]        rd_ext;

  assign posx      = MW'(cmd_i.pos);
  assign cntx      = MW'(cnt_q);
  assign val_ext   = EW'(cmd_i.value);
  assign rd_signed = rdata_q;
  assign rd_ext    = EW'(rd_signed);
  assign adv       = !ov_q || m_tready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ins_d       = ins_q;
    pos_d       = pos_q;
    val_d       = val_q;
    dst_d       = dst_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    wdst_d      = wdst_q;
    k_d         = k_q;
    rv_d        = rv_q;
    rslot_d     = rslot_q;
    rep_st_d    = rep_st_q;
    rep_empty_d = rep_empty_q;
    ov_d        = ov_q && !m_tready_i;
    ost_d       = ost_q;
    oel_d       = oel_q;
    oslot_d     = oslot_q;
    oempty_d    = oempty_q;
    olast_d     = olast_q;
    we          = 1'b0;
    waddr       = wdst_q;
    wdata       = rdata_q;
    re          = 1'b0;
    raddr       = k_q[AW-1:0];
    pop_o       = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          pend_d = 1'b0;
          pos_d = posx[AW-1:0];
          val_d = val_ext[WORD_BITS-1:0];
          case (cmd_i.op)
            CMD_INSERT: begin
              ins_d   = 1'b1;
              rem_d   = CW'(cntx - posx);
              dst_d   = cnt_q[AW-1:0];
              cnt_d   = cnt_q + 1'b1;
              state_d = B_SHIFT;
            end
            CMD_DELETE: begin
              ins_d   = 1'b0;
              rem_d   = CW'(cntx - MW'(1) - posx);
              dst_d   = posx[AW-1:0];
              cnt_d   = cnt_q - 1'b1;
              state_d = B_SHIFT;
            end
            default: begin
              rep_st_d    = cmd_i.status;
              rep_empty_d = cmd_i.empty;
              state_d     = B_REPORT;
            end
          endcase
        end
      end

      B_SHIFT: begin
        // Write back the word read last cycle while the next one is read
        if (pend_q) begin
          we    = 1'b1;
          waddr = wdst_q;
          wdata = rdata_q;
        end
        if (rem_q != '0) begin
          re     = 1'b1;
          raddr  = ins_q ? dst_q - 1'b1 : dst_q + 1'b1;
          wdst_d = dst_q;
          dst_d  = ins_q ? dst_q - 1'b1 : dst_q + 1'b1;
          rem_d  = rem_q - 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (ins_q) begin
              we    = 1'b1;
              waddr = pos_q;
              wdata = val_q;
            end
            k_d  = '0;
            rv_d = 1'b0;
            if (cnt_q == '0) begin
              rep_st_d    = ST_DONE;
              rep_empty_d = 1'b1;
              state_d     = B_REPORT;
            end else begin
              state_d = B_STREAM;
            end
          end
        end
      end

      B_STREAM: begin
        if ((k_q < cnt_q) && (!rv_q || adv)) begin
          re      = 1'b1;
          raddr   = k_q[AW-1:0];
          k_d     = k_q + 1'b1;
          rv_d    = 1'b1;
          rslot_d = k_q;
        end else if (adv) begin
          rv_d = 1'b0;
        end
        if (adv && rv_q) begin
          ov_d     = 1'b1;
          ost_d    = ST_DONE;
          oel_d    = rd_ext[ELEM_W-1:0];
          oslot_d  = SLOT_W'(rslot_q);
          oempty_d = 1'b0;
          olast_d  = (CW'(rslot_q + 1'b1) == cnt_q);
        end
        if ((k_q == cnt_q) && !rv_q) begin
          state_d = B_IDLE;
        end
      end

      B_REPORT: begin
        if (adv) begin
          ov_d     = 1'b1;
          ost_d    = rep_st_q;
          oel_d    = '0;
          oslot_d  = '0;
          oempty_d = rep_empty_q;
          olast_d  = 1'b1;
          state_d  = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
      rem_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
      rem_q   <= rem_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q       <= ins_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    dst_q       <= dst_d;
    wdst_q      <= wdst_d;
    rslot_q     <= rslot_d;
    rep_st_q    <= rep_st_d;
    rep_empty_q <= rep_empty_d;
    ost_q       <= ost_d;
    oel_q       <= oel_d;
    oslot_q     <= oslot_d;
    oempty_q    <= oempty_d;
    olast_q     <= olast_d;
  end

  // Array memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {{M_PAD_W{1'b0}}, oslot_q, oel_q};
  assign m_tuser_o  = {oempty_q, ost_q};
  assign m_tlast_o  = olast_q;

endmodule
